// ===== rtl/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg: half-band decimator shared definitions
// Widths, sample and coefficient types, sequencer phase codes and the lane
// control bundle used by the lanes and the top level.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int SECTIONS       = 4;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 17;

  localparam int LANES        = 4;
  localparam int INNER_BITS   = SAMPLE_BITS + 2;
  localparam int EXT_BITS     = INNER_BITS - SAMPLE_BITS;
  localparam int COEF_BITS    = COEF_FRAC_BITS + 1;
  localparam int PROD_BITS    = COEF_BITS + 1 + INNER_BITS;
  localparam int SHIFT_BITS   = PROD_BITS - COEF_FRAC_BITS;
  localparam int SUM_BITS     = SHIFT_BITS + 1;
  localparam int SEC_IDX_BITS = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CFG_REGS     = 2 * SECTIONS;
  localparam int CFG_IDX_BITS = $clog2(CFG_REGS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [INNER_BITS-1:0]  inner_t;
  typedef logic        [COEF_BITS-1:0]   coef_t;

  // Per-section phases of one lane
  localparam logic [1:0] PH_MUL_X = 2'd0;
  localparam logic [1:0] PH_ADD   = 2'd1;
  localparam logic [1:0] PH_MUL_O = 2'd2;
  localparam logic [1:0] PH_SUB   = 2'd3;

  typedef struct packed {
    logic                    load;
    logic                    run;
    logic [1:0]              phase;
    logic [SEC_IDX_BITS-1:0] sec;
  } hbd_lane_ctrl_t;

endpackage

// ===== rtl/hbd_if.sv =====
// ----------------------------------------------------------------------------
// hbd_if: stream channels of the half-band decimator
// Input channel carries the even and odd samples of both channels, output
// channel carries the decimated stereo pair.
// ----------------------------------------------------------------------------
interface hbd_in_if import hbd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_even;
  sample_t left_odd;
  sample_t right_even;
  sample_t right_odd;

  modport source (output valid, left_even, left_odd, right_even, right_odd, input ready);
  modport sink   (input valid, left_even, left_odd, right_even, right_odd, output ready);
endinterface

interface hbd_out_if import hbd_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_out;
  sample_t right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

// ===== rtl/hbd_lane.sv =====
// ----------------------------------------------------------------------------
// hbd_lane: one allpass cascade lane
// Runs the sections of one lane in turn on a shared multiplier, four
// phases per section, and keeps the section states of this lane.
// ----------------------------------------------------------------------------
module hbd_lane import hbd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hbd_lane_ctrl_t ctrl_i,
  input  coef_t          coef_i,
  input  inner_t         x_i,
  output inner_t         v_o
);

  inner_t                        x_q;
  inner_t                        o_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  inner_t                        state_q [SECTIONS];

  inner_t                        mul_src;
  logic signed [PROD_BITS-1:0]   prod_d;
  logic signed [SHIFT_BITS-1:0]  prod_sh;
  logic signed [SUM_BITS-1:0]    add_sum;
  logic signed [SUM_BITS-1:0]    sub_sum;

  function automatic inner_t sat_inner(logic signed [SUM_BITS-1:0] v);
    if ((&v[SUM_BITS-1:INNER_BITS-1]) || !(|v[SUM_BITS-1:INNER_BITS-1])) begin
      return v[INNER_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      return {1'b1, {(INNER_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(INNER_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    mul_src = (ctrl_i.phase == PH_MUL_X) ? x_q : o_q;
    prod_d  = PROD_BITS'($signed({1'b0, coef_i})) * PROD_BITS'(mul_src);
    // floor of the product scaled back by the coefficient fraction
    prod_sh = $signed(prod_q[PROD_BITS-1:COEF_FRAC_BITS]);
    add_sum = SUM_BITS'(state_q[ctrl_i.sec]) + SUM_BITS'(prod_sh);
    sub_sum = SUM_BITS'(x_q) - SUM_BITS'(prod_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        state_q[i] <= '0;
      end
    end else if (ctrl_i.run && ctrl_i.phase == PH_SUB) begin
      state_q[ctrl_i.sec] <= sat_inner(sub_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      x_q <= x_i;
    end else if (ctrl_i.run) begin
      unique case (ctrl_i.phase)
        PH_MUL_X: prod_q <= prod_d;
        PH_ADD:   o_q    <= sat_inner(add_sum);
        PH_MUL_O: prod_q <= prod_d;
        PH_SUB:   x_q    <= o_q;
        default:  x_q    <= x_q;
      endcase
    end
  end

  assign v_o = x_q;

endmodule

// ===== rtl/hbd_merge.sv =====
// ----------------------------------------------------------------------------
// hbd_merge: branch merge and output register
// Averages each direct result with the delayed result of the previous
// item, saturates to the sample width and holds the new delayed results.
// ----------------------------------------------------------------------------
module hbd_merge import hbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  inner_t  v_i [LANES],
  output sample_t left_o,
  output sample_t right_o
);

  localparam int MSUM_BITS = INNER_BITS + 1;

  inner_t  held_q [2];
  sample_t out_q  [2];
  sample_t out_d  [2];

  function automatic sample_t sat_sample(logic signed [INNER_BITS-1:0] v);
    if ((&v[INNER_BITS-1:SAMPLE_BITS-1]) || !(|v[INNER_BITS-1:SAMPLE_BITS-1])) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[INNER_BITS-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      logic signed [MSUM_BITS-1:0] sum;
      sum       = MSUM_BITS'(held_q[ch]) + MSUM_BITS'(v_i[2*ch]);
      // drop the low bit: floor of half the sum
      out_d[ch] = sat_sample(sum[MSUM_BITS-1:1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q[0] <= '0;
      held_q[1] <= '0;
    end else if (fire_i) begin
      held_q[0] <= v_i[1];
      held_q[1] <= v_i[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      out_q[0] <= out_d[0];
      out_q[1] <= out_d[1];
    end
  end

  assign left_o  = out_q[0];
  assign right_o = out_q[1];

endmodule

// ===== rtl/halfband_allpass_decimator_2x_unit.sv =====
// ----------------------------------------------------------------------------
// halfband_allpass_decimator_2x_unit: stereo 2x polyphase allpass decimator
// Four lanes run the direct and delayed cascades of both channels in
// parallel; a merge stage forms the decimated pair.
// Input is accepted only in the idle state, so a new item waits until the
// previous one has run the four-phase section step on each lane's single
// multiplier and been merged; a result still waiting on the output holds
// the merge step.
// Reset: coefficients return to 1.0, section and held states clear to zero.
// ----------------------------------------------------------------------------
module halfband_allpass_decimator_2x_unit import hbd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  coef_t                   cfg_data_i,
  hbd_in_if.sink                  in_if,
  hbd_out_if.source               out_if
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  localparam logic [SEC_IDX_BITS-1:0] SEC_LAST = SEC_IDX_BITS'(SECTIONS - 1);

  logic [1:0]              state_q, state_d;
  logic [1:0]              phase_q, phase_d;
  logic [SEC_IDX_BITS-1:0] sec_q, sec_d;
  logic                    out_valid_q, out_valid_d;

  coef_t direct_q  [SECTIONS];
  coef_t delayed_q [SECTIONS];

  logic           in_xfer;
  logic           out_xfer;
  logic           fire;
  hbd_lane_ctrl_t ctrl;
  inner_t         lane_x [LANES];
  inner_t         lane_v [LANES];
  sample_t        in_samples [LANES];

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_xfer    = out_if.valid && out_if.ready;
  assign fire        = (state_q == ST_MERGE) && (!out_valid_q || out_if.ready);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SECTIONS; i++) begin
        direct_q[i]  <= coef_t'(1) << COEF_FRAC_BITS;
        delayed_q[i] <= coef_t'(1) << COEF_FRAC_BITS;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < CFG_IDX_BITS'(SECTIONS)) begin
        direct_q[cfg_idx_i[SEC_IDX_BITS-1:0]] <= cfg_data_i;
      end else if (32'(cfg_idx_i) < CFG_REGS) begin
        delayed_q[SEC_IDX_BITS'(cfg_idx_i - CFG_IDX_BITS'(SECTIONS))] <= cfg_data_i;
      end
    end
  end

  // Section sequencer
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    sec_d       = sec_q;
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_RUN;
          phase_d = PH_MUL_X;
          sec_d   = '0;
        end
      end
      ST_RUN: begin
        phase_d = phase_q + 2'd1;
        if (phase_q == PH_SUB) begin
          if (sec_q == SEC_LAST) begin
            state_d = ST_MERGE;
          end else begin
            sec_d = sec_q + SEC_IDX_BITS'(1);
          end
        end
      end
      ST_MERGE: begin
        if (fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_MUL_X;
      sec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      sec_q       <= sec_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign ctrl.load  = in_xfer;
  assign ctrl.run   = (state_q == ST_RUN);
  assign ctrl.phase = phase_q;
  assign ctrl.sec   = sec_q;

  assign in_samples[0] = in_if.left_even;
  assign in_samples[1] = in_if.left_odd;
  assign in_samples[2] = in_if.right_even;
  assign in_samples[3] = in_if.right_odd;

  // Lanes: left direct, left delayed, right direct, right delayed
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    assign lane_x[l] = {{EXT_BITS{in_samples[l][SAMPLE_BITS-1]}}, in_samples[l]};

    hbd_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .coef_i ((l % 2 == 1) ? delayed_q[sec_q] : direct_q[sec_q]),
      .x_i    (lane_x[l]),
      .v_o    (lane_v[l])
    );
  end

  hbd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .v_i     (lane_v),
    .left_o  (out_if.left_out),
    .right_o (out_if.right_out)
  );

  assign out_if.valid = out_valid_q;

`ifndef SYNTH
  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_RUN) && (sec_q == '0) && (phase_q == PH_MUL_X))
    else $error("input transfer did not start the section sequence");

  a_valid_from_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_MERGE)
    else $error("output valid rose outside the merge step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_if.ready) |=> !$rose(out_valid_q) && (state_q != ST_IDLE
      || !$past(state_q == ST_MERGE)))
    else $error("pending result overwritten by merge");
`endif

endmodule
